FILE: sv/iale_pkg.sv
// Shared types, codes and widths for the indexed array list engine.
package iale_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int FUNC_W       = 3;
  localparam int POS_W        = 10;
  localparam int WORD_W       = 32;
  localparam int LEN_W        = 11;
  localparam int STATUS_W     = 2;

  typedef enum logic [FUNC_W-1:0] {
    F_APPEND = 3'd0,
    F_POP    = 3'd1,
    F_READ   = 3'd2,
    F_WRITE  = 3'd3,
    F_INSERT = 3'd4,
    F_DELETE = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_word;
    logic [LEN_W-1:0]         length;
    logic [STATUS_W-1:0]      status;
  } out_item_t;

endpackage

FILE: sv/indexed_array_list_engine.sv
// Ordered word list in a single-port-write, registered-read memory with a live entry count.
// One request is handled at a time. Append, pop, write and rejected requests answer in the
// cycle after they are accepted; a read answers once the registered memory read is back. Insert
// and delete move the entries behind the index one place through the memory, one entry per
// cycle in a read/write-back pipeline (S_SHIFT and S_DRAIN). The memory contents are not
// cleared at reset; only entries below the count are ever read. The input is held off while
// a request is in progress or a finished item is still stalled at the output.
module indexed_array_list_engine #(
  parameter int CAPACITY = iale_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iale_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output iale_pkg::out_item_t out_item
);
  import iale_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_DRAIN = 5'b00100,
    S_PUT   = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [AW-1:0]    end_r, end_nxt;
  logic [AW-1:0]    pa_r, pa_nxt;
  logic             pend_r, pend_nxt;
  logic [FUNC_W-1:0] op_r;
  logic [AW-1:0]    pos_r;
  logic [WORD_W-1:0] word_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic [WORD_W-1:0] store_mem [CAPACITY];
  logic [WORD_W-1:0] rd_data_r;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data;

  logic          accept;
  logic          full, empty, ins;
  logic [PW-1:0] pos_w, cnt_w;
  logic          load;
  logic [WORD_W-1:0] res_word;
  status_t       res_status;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);
  assign pos_w = PW'(in_item.position);
  assign cnt_w = PW'(count_r);
  assign ins   = (op_r == F_INSERT);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rp_nxt        = rp_r;
    end_nxt       = end_r;
    pa_nxt        = pa_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    load          = 1'b0;
    res_word      = '0;
    res_status    = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (in_item.func)
            F_APPEND: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = AW'(count_r);
                wr_data   = in_item.word_in;
                count_nxt = count_r + CW'(1);
              end
            end
            F_POP: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            F_READ: begin
              if (pos_w < cnt_w) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_item.position);
                load      = 1'b0;
                state_nxt = S_READ;
              end else begin
                res_word   = '1;
                res_status = ST_RANGE;
              end
            end
            F_WRITE: begin
              if (pos_w < cnt_w) begin
                wr_en   = 1'b1;
                wr_addr = AW'(in_item.position);
                wr_data = in_item.word_in;
              end else begin
                res_status = ST_RANGE;
              end
            end
            F_INSERT: begin
              if (full) begin
                res_status = ST_FULL;
              end else if (pos_w > cnt_w) begin
                res_status = ST_RANGE;
              end else begin
                count_nxt = count_r + CW'(1);
                load      = 1'b0;
                pend_nxt  = 1'b0;
                if (pos_w == cnt_w) begin
                  state_nxt = S_PUT;
                end else begin
                  // walk down from the tail, each entry moves up one place
                  rp_nxt    = AW'(count_r - CW'(1));
                  end_nxt   = AW'(in_item.position);
                  state_nxt = S_SHIFT;
                end
              end
            end
            F_DELETE: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else if (pos_w >= cnt_w) begin
                res_status = ST_RANGE;
              end else begin
                count_nxt = count_r - CW'(1);
                pend_nxt  = 1'b0;
                if (pos_w != cnt_w - PW'(1)) begin
                  // walk up from the entry after the index, each moves down one place
                  rp_nxt    = AW'(in_item.position) + AW'(1);
                  end_nxt   = AW'(count_r - CW'(1));
                  load      = 1'b0;
                  state_nxt = S_SHIFT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        rd_en    = 1'b1;
        rd_addr  = rp_r;
        pend_nxt = 1'b1;
        pa_nxt   = ins ? (rp_r + AW'(1)) : (rp_r - AW'(1));
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pa_r;
          wr_data = rd_data_r;
        end
        if (rp_r == end_r) begin
          state_nxt = S_DRAIN;
        end else begin
          rp_nxt = ins ? (rp_r - AW'(1)) : (rp_r + AW'(1));
        end
      end
      S_DRAIN: begin
        // write back the last entry read
        wr_en    = 1'b1;
        wr_addr  = pa_r;
        wr_data  = rd_data_r;
        pend_nxt = 1'b0;
        if (ins) begin
          state_nxt = S_PUT;
        end else begin
          load      = 1'b1;
          count_nxt = count_r;
          state_nxt = S_IDLE;
        end
      end
      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = word_r;
        load      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        load      = 1'b1;
        res_word  = rd_data_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.read_word = res_word;
      out_item_nxt.length    = LEN_W'(count_nxt);
      out_item_nxt.status    = res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_r       <= rp_nxt;
    end_r      <= end_nxt;
    pa_r       <= pa_nxt;
    out_item_r <= out_item_nxt;
    if (accept) begin
      op_r   <= in_item.func;
      pos_r  <= AW'(in_item.position);
      word_r <= in_item.word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

endmodule

FILE: sv/iale_checker.sv
// Port-level checks for the indexed array list engine, bound to the top level.
module iale_checker #(
  parameter int CAPACITY = iale_pkg::CAPACITY_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input iale_pkg::out_item_t out_item
);
  import iale_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_FULL) |-> out_item.length == LEN_W'(CAPACITY))
    else $error("full status with list not at capacity");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_EMPTY) |-> out_item.length == '0)
    else $error("empty status with a non-empty list");

  a_range_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_RANGE) |->
      (out_item.read_word == '0) || (out_item.read_word == '1))
    else $error("range error carries a stray read word");

endmodule

bind indexed_array_list_engine iale_checker #(.CAPACITY(CAPACITY)) u_iale_checker (.*);
